// ----- hw/rtl/u8b_pkg.sv -----
// ----------------------------------------------------------------------------
// u8b_pkg
// Shared types and constants for the UTF-8 to BMP code point decoder.
// ----------------------------------------------------------------------------
package u8b_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 16;
    localparam int CNT_W  = 16;
    localparam int BL_W   = 2;

    localparam logic [BYTE_W-1:0] LEAD3_THRESH = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_THRESH = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK   = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK   = 8'h1F;
    localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h3F;

    localparam logic [BL_W-1:0] BL_NONE = 2'd0;
    localparam logic [BL_W-1:0] BL_ONE  = 2'd1;
    localparam logic [BL_W-1:0] BL_TWO  = 2'd2;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_LEAD2,
        KIND_LEAD3
    } byte_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_string;
        byte_kind_t        kind;
    } item_t;

    typedef struct packed {
        logic         last_char;
        logic [CNT_W-1:0] char_index;
        logic [CP_W-1:0]  code_point;
    } result_t;

endpackage

// ----- hw/rtl/u8b_front.sv -----
// ----------------------------------------------------------------------------
// u8b_front
// Input side: accepts bytes and tags each with its lead-byte class.
// ----------------------------------------------------------------------------
module u8b_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [u8b_pkg::BYTE_W-1:0]   s_tdata,
    input  logic                         s_tlast,
    output logic                         push,
    output u8b_pkg::item_t               push_item,
    input  logic                         queue_full
);
    import u8b_pkg::*;

    byte_kind_t kind;

    always_comb
    begin
        if (s_tdata > LEAD3_THRESH)
        begin
            kind = KIND_LEAD3;
        end
        else if (s_tdata > LEAD2_THRESH)
        begin
            kind = KIND_LEAD2;
        end
        else
        begin
            kind = KIND_SINGLE;
        end
    end

    assign s_tready                = !queue_full;
    assign push                    = s_tvalid && !queue_full;
    assign push_item.byte_value    = s_tdata;
    assign push_item.end_of_string = s_tlast;
    assign push_item.kind          = kind;

endmodule

// ----- hw/rtl/u8b_queue.sv -----
// ----------------------------------------------------------------------------
// u8b_queue
// Two-entry item queue between the front and back parts.
// ----------------------------------------------------------------------------
module u8b_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u8b_pkg::item_t push_item,
    input  logic           pop,
    output u8b_pkg::item_t pop_item,
    output logic           empty,
    output logic           full
);
    import u8b_pkg::*;

    item_t       mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/u8b_back.sv -----
// ----------------------------------------------------------------------------
// u8b_back
// Decode side: assembles code points, tracks capacity, holds the result.
// ----------------------------------------------------------------------------
module u8b_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [u8b_pkg::CNT_W-1:0]   capacity,
    input  logic                        queue_empty,
    input  u8b_pkg::item_t              item,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output u8b_pkg::result_t            result
);
    import u8b_pkg::*;

    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;
    logic [BL_W-1:0]  bl_reg;
    logic [BL_W-1:0]  bl_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full_reg;
    logic             full_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;

    logic             starting;
    logic             at_limit_now;
    logic             full_now;
    logic [CNT_W-1:0] cap_m1;
    logic [CNT_W:0]   count_inc;
    logic [CP_W-1:0]  cp;
    logic [BL_W-1:0]  bl_dec;
    logic [CP_W-1:0]  cont_bits;

    assign pop       = !queue_empty && (!out_valid_reg || m_tready);
    assign starting  = (bl_reg != BL_ONE) && (bl_reg != BL_TWO);
    assign cap_m1    = capacity - 16'd1;
    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign at_limit_now = (capacity != '0) && (count_reg >= cap_m1);
    assign full_now     = (capacity != '0) && (count_inc >= {1'b0, cap_m1});
    assign cont_bits    = {8'd0, item.byte_value & CONT_MASK};

    always_comb
    begin
        cp     = partial_reg;
        bl_dec = BL_NONE;
        if (starting)
        begin
            case (item.kind)
                KIND_LEAD3:
                begin
                    cp     = {item.byte_value[3:0] & LEAD3_MASK[3:0], 12'd0};
                    bl_dec = BL_TWO;
                end
                KIND_LEAD2:
                begin
                    cp     = {5'd0, item.byte_value[4:0] & LEAD2_MASK[4:0], 6'd0};
                    bl_dec = BL_ONE;
                end
                default:
                begin
                    cp     = {8'd0, item.byte_value};
                    bl_dec = BL_NONE;
                end
            endcase
        end
        else if (bl_reg == BL_TWO)
        begin
            cp     = partial_reg | (cont_bits << 6);
            bl_dec = BL_ONE;
        end
        else
        begin
            cp     = partial_reg | cont_bits;
            bl_dec = BL_NONE;
        end
    end

    always_comb
    begin
        partial_next   = partial_reg;
        bl_next        = bl_reg;
        count_next     = count_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        if (pop)
        begin
            if (full_reg || (starting && at_limit_now))
            begin
                // over capacity: drop until end of string
                partial_next = '0;
                bl_next      = BL_NONE;
                if (item.end_of_string)
                begin
                    count_next = '0;
                    full_next  = 1'b0;
                end
                else
                begin
                    full_next = 1'b1;
                end
            end
            else if (bl_dec == BL_NONE || item.end_of_string)
            begin
                out_valid_next       = 1'b1;
                out_next.code_point  = cp;
                out_next.char_index  = count_reg;
                out_next.last_char   = item.end_of_string || full_now;
                partial_next         = '0;
                bl_next              = BL_NONE;
                if (item.end_of_string)
                begin
                    count_next = '0;
                    full_next  = 1'b0;
                end
                else
                begin
                    count_next = count_inc[CNT_W-1:0];
                    full_next  = full_now;
                end
            end
            else
            begin
                partial_next = cp;
                bl_next      = bl_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            bl_reg        <= BL_NONE;
            count_reg     <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            bl_reg        <= bl_next;
            count_reg     <= count_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule

// ----- hw/rtl/utf8_to_bmp_code_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_to_bmp_code_decoder_unit
// UTF-8 byte stream to 16-bit code point decoder with capacity limit.
//
//  channel  dir  fields
//  s_*      in   tdata[7:0] byte_value; tlast end_of_string
//  m_*      out  tdata[15:0] code_point, [31:16] char_index; tlast last_char
//  cfg_*    in   wr_data[15:0] capacity
//
// One byte per cycle sustained unless the output stalls; a result passes
// the queue, then the output register, after its final byte is accepted.
// The decode state is updated once per byte. Reset clears state and capacity.
// Output stalls back up through the two-entry queue to s_tready.
// ----------------------------------------------------------------------------
module utf8_to_bmp_code_decoder_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] byte_value
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,    // [15:0] code_point, [31:16] char_index
    output logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic [u8b_pkg::CNT_W-1:0]   cfg_wr_data
);
    import u8b_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    logic             push;
    item_t            push_item;
    logic             pop;
    item_t            pop_item;
    logic             q_empty;
    logic             q_full;
    result_t          result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    u8b_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (q_full)
    );

    u8b_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    u8b_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (cap_reg),
        .queue_empty (q_empty),
        .item        (pop_item),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result      (result)
    );

    assign m_tdata = {result.char_index, result.code_point};
    assign m_tlast = result.last_char;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to BMP code point decoder. A short
// directed plan hits lead-byte thresholds, truncated strings, the zero byte
// and capacity limits, including a capacity lowered mid-string. Random
// strings follow, mostly well-formed sequences with some noise and
// truncation, under changing capacity. Random gaps are applied on the input
// side and random stalls on the output side. Every result is compared with
// a bit-exact decode predictor or with a typed value from the plan.
// ----------------------------------------------------------------------------
module tb_top;
    import u8b_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RST_CYCLES = 12;
    localparam int LAT_PAD    = 8;
    localparam int RAND_ITEMS = 700;
    localparam int PLAN_LEN   = 34;

    typedef enum {ROW_BYTE, ROW_CAP} row_op_t;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_TYPED} row_chk_t;

    typedef struct {
        row_op_t     op;
        logic [15:0] value;
        logic        eos;
        row_chk_t    chk;
        logic [15:0] w_cp;
        logic [15:0] w_idx;
        logic        w_last;
    } plan_row_t;

    typedef struct {
        logic [7:0] b;
        logic       eos;
    } str_byte_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_wr_en;
    logic [CNT_W-1:0]  cfg_wr_data;

    // decoder state mirror
    logic [15:0]  pend_code;
    logic [1:0]   pend_left;
    int unsigned  chars_out;
    bit           buf_full;
    int unsigned  cap_reg;

    result_t      cp_expect_q[$];
    str_byte_t    str_q[$];
    int           err_count;
    bit           quiet;

    utf8_to_bmp_code_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report(input string msg);
        if (err_count < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit over_cap(input int unsigned count);
        return cap_reg != 0 && count >= cap_reg - 1;
    endfunction

    function automatic void clear_string();
        pend_code = '0;
        pend_left = BL_NONE;
        chars_out = 0;
        buf_full  = 1'b0;
    endfunction

    // returns 1 when the byte completes (or truncates) a character
    function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                       output result_t r);
        bit lead;
        bit full_now;
        r = '0;
        lead = (pend_left != BL_ONE && pend_left != BL_TWO);
        if (buf_full || (lead && over_cap(chars_out)))
        begin
            if (eos)
                clear_string();
            else
            begin
                buf_full  = 1'b1;
                pend_code = '0;
                pend_left = BL_NONE;
            end
            return 1'b0;
        end
        if (lead)
        begin
            if (b > LEAD3_THRESH)
            begin
                pend_code = {b[3:0] & LEAD3_MASK[3:0], 12'h000};
                pend_left = BL_TWO;
            end
            else if (b > LEAD2_THRESH)
            begin
                pend_code = {5'd0, b[4:0] & LEAD2_MASK[4:0], 6'd0};
                pend_left = BL_ONE;
            end
            else
            begin
                pend_code = {8'h00, b};
                pend_left = BL_NONE;
            end
        end
        else if (pend_left == BL_TWO)
        begin
            pend_code = pend_code | {4'd0, b[5:0] & CONT_MASK[5:0], 6'd0};
            pend_left = BL_ONE;
        end
        else
        begin
            pend_code = pend_code | {10'd0, b[5:0] & CONT_MASK[5:0]};
            pend_left = BL_NONE;
        end
        if (pend_left != BL_NONE && !eos)
            return 1'b0;
        full_now     = over_cap(chars_out + 1);
        r.code_point = pend_code;
        r.char_index = chars_out[15:0];
        r.last_char  = eos || full_now;
        if (eos)
            clear_string();
        else
        begin
            chars_out = (chars_out + 1) & 32'h0000_FFFF;
            pend_code = '0;
            pend_left = BL_NONE;
            if (full_now)
                buf_full = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic eos,
                            input row_chk_t chk, input result_t want);
        int      gap;
        result_t r;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (decode_byte(b, eos, r) && chk == CHK_MODEL)
            cp_expect_q.push_back(r);
        else if (chk == CHK_TYPED)
            cp_expect_q.push_back(want);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (cp_expect_q.size() != 0)
            @(posedge clk);
        repeat (LAT_PAD) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [15:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cap_reg = value;
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    task automatic make_string();
        logic [7:0] txt[$];
        int         nchars;
        int         r;
        bit         cut;
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                              : $urandom_range(1, 8);
        for (int c = 0; c < nchars; c++)
        begin
            r   = $urandom_range(0, 99);
            cut = (c == nchars - 1) && ($urandom_range(0, 3) == 0);
            if (r < 45)
                txt.push_back(8'($urandom_range(1, 127)));
            else if (r < 65)
            begin
                txt.push_back(8'($urandom_range(8'hC1, 8'hDF)));
                if (!cut)
                    txt.push_back(cont_byte());
            end
            else if (r < 85)
            begin
                txt.push_back(8'($urandom_range(8'hE1, 8'hFF)));
                txt.push_back(cont_byte());
                if (!cut)
                    txt.push_back(cont_byte());
            end
            else
                txt.push_back(8'($urandom_range(1, 255)));
        end
        foreach (txt[i])
            str_q.push_back('{txt[i], i == txt.size() - 1});
    endtask

    initial
    begin : sink_ready
        int hold;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            hold = $urandom_range(1, 40);
            repeat (hold) @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cp_expect_q.size() == 0)
                report($sformatf("unexpected result cp=%h idx=%0d last=%b",
                                 m_tdata[15:0], m_tdata[31:16], m_tlast));
            else
            begin
                exp_r = cp_expect_q.pop_front();
                if (m_tdata[15:0] !== exp_r.code_point)
                    report($sformatf("code_point got %h want %h",
                                     m_tdata[15:0], exp_r.code_point));
                if (m_tdata[31:16] !== exp_r.char_index)
                    report($sformatf("char_index got %0d want %0d",
                                     m_tdata[31:16], exp_r.char_index));
                if (m_tlast !== exp_r.last_char)
                    report($sformatf("last_char got %b want %b",
                                     m_tlast, exp_r.last_char));
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t  plan [0:PLAN_LEN-1];
        result_t    want;
        str_byte_t  sb;
        int         sent;
        int         phase_len;
        int         r;
        logic [15:0] cap;

        plan = '{
            '{ROW_BYTE, 16'h41, 1'b0, CHK_TYPED, 16'h0041, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h01, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'hFF, 1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'hBF, 1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'hBF, 1'b0, CHK_TYPED, 16'hFFFF, 16'd2, 1'b0},
            '{ROW_BYTE, 16'hE0, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h80, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'hC0, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'hC1, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h80, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h00, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'hE2, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h82, 1'b1, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_CAP,  16'd1,  1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h61, 1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h62, 1'b1, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_CAP,  16'd2,  1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h63, 1'b0, CHK_TYPED, 16'h0063, 16'd0, 1'b1},
            '{ROW_BYTE, 16'h64, 1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h65, 1'b1, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_CAP,  16'd0,  1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h61, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'hE4, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            // capacity drops while a three-byte form is open
            '{ROW_CAP,  16'd1,  1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h80, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h80, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h41, 1'b1, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_CAP,  16'd0,  1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h70, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            // count already at the new limit: next lead is dropped
            '{ROW_CAP,  16'd2,  1'b0, CHK_NONE,  16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h71, 1'b0, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h72, 1'b1, CHK_MODEL, 16'h0, 16'd0, 1'b0},
            '{ROW_CAP,  16'hFFFF, 1'b0, CHK_NONE, 16'h0, 16'd0, 1'b0},
            '{ROW_BYTE, 16'h7E, 1'b1, CHK_TYPED, 16'h007E, 16'd0, 1'b1}
        };

        err_count   = 0;
        quiet       = 1'b0;
        cap_reg     = 0;
        clear_string();
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].op == ROW_CAP)
                set_capacity(plan[i].value);
            else
            begin
                want.code_point = plan[i].w_cp;
                want.char_index = plan[i].w_idx;
                want.last_char  = plan[i].w_last;
                put_byte(plan[i].value[7:0], plan[i].eos, plan[i].chk, want);
            end
        end

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                cap = 16'd0;
            else if (r < 7)
                cap = 16'($urandom_range(1, 6));
            else if (r == 7)
                cap = 16'($urandom_range(7, 40));
            else if (r == 8)
                cap = 16'hFFFF;
            else
                cap = 16'($urandom_range(0, 65535));
            set_capacity(cap);
            quiet = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 80);
            repeat (phase_len)
            begin
                if (str_q.size() == 0)
                    make_string();
                sb = str_q.pop_front();
                put_byte(sb.b, sb.eos, CHK_MODEL, '0);
                sent++;
            end
        end
        while (str_q.size() != 0)
        begin
            sb = str_q.pop_front();
            put_byte(sb.b, sb.eos, CHK_MODEL, '0);
        end

        wait_drained();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
